/* rtl/mtbg_pkg.sv */
`default_nettype none
package mtbg_pkg;
    localparam int unsigned StateWords  = 624;
    localparam int unsigned ShiftOffset = 397;
    localparam int unsigned IdxW        = 10;

    localparam logic [31:0] InitMult    = 32'd1812433253;
    localparam logic [31:0] PairBase    = 32'd19650218;
    localparam logic [31:0] PairMultA   = 32'd1664525;
    localparam logic [31:0] PairMultB   = 32'd1566083941;
    localparam logic [31:0] MatrixA     = 32'h9908b0df;
    localparam logic [31:0] TemperB     = 32'h9d2c5680;
    localparam logic [31:0] TemperC     = 32'hefc60000;
    localparam logic [31:0] UpperMask   = 32'h80000000;
    localparam logic [31:0] LowerMask   = 32'h7fffffff;
    localparam logic [31:0] ResetSeedLo = 32'd5489;
    localparam logic [31:0] ResetSeedHi = 32'd0;

    typedef enum logic [1:0] {
        CMD_RESEED  = 2'd0,
        CMD_DRAW    = 2'd1,
        CMD_BOUNDED = 2'd2,
        CMD_REAL    = 2'd3
    } t_cmd;

    localparam logic REG_SEED_LO = 1'b0;
    localparam logic REG_SEED_HI = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_S1_RD,     // single init: read previous word
        ST_S1_MUL,    // multiply and write
        ST_P1_RD,     // pair pass 1: read prev
        ST_P1_RD2,    // read current
        ST_P1_MUL,
        ST_P1_WR,
        ST_P2_RD,
        ST_P2_RD2,
        ST_P2_MUL,
        ST_P2_WR,
        ST_WRAP_RD,   // copy last word to entry 0
        ST_WRAP_WR,
        ST_FIN_WR,    // entry 0 becomes the top bit only
        ST_G_RD0,     // regenerate: read kk
        ST_G_RD1,     // read kk+1
        ST_G_RD2,     // read kk+397
        ST_G_WR,
        ST_D_RD,      // draw: read word at index
        ST_D_TEMP,
        ST_D_USE,
        ST_OUT
    } t_state;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [63:0] fill_mask(input logic [63:0] x);
        logic [63:0] m;
        m = x;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
        return m;
    endfunction
endpackage
`default_nettype wire

/* rtl/mt19937_bounded_generator.sv */
`default_nettype none
// MT19937 generator with a 624-word state table in one single-port memory and
// one shared 32x32 multiplier under a sequencer. One item is in work at a time;
// s_axis_tready is high only while idle. A raw draw reads one word; every 624
// words the draw first regenerates the whole table. A real draw takes two words,
// a bounded draw one or two words per try until a try is accepted; a zero limit
// returns 0 at once. A reseed uses a single-word seed, or a two-word seed if the
// high word is nonzero. After reset the block seeds itself from the reset
// seed before it accepts the first item. The result sits in an output register
// until taken. tdata in: command[1:0], limit[65:2], zero fill to 72 bits.
module mt19937_bounded_generator #(
    parameter int unsigned STATE_WORDS  = mtbg_pkg::StateWords,
    parameter int unsigned SHIFT_OFFSET = mtbg_pkg::ShiftOffset
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // command[1:0], limit[65:2]
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [63:0] m_axis_tdata   // value[63:0]
);
    import mtbg_pkg::*;

    localparam int unsigned AW = $clog2(STATE_WORDS + 1);
    localparam logic [AW-1:0] LastIdx = AW'(STATE_WORDS - 1);
    localparam logic [AW-1:0] Full    = AW'(STATE_WORDS);
    localparam logic [AW-1:0] FarOff  = AW'(SHIFT_OFFSET);

    logic [31:0] r_mem [STATE_WORDS];
    logic [31:0] r_rd;

    t_state r_state, n_state;
    logic [31:0] r_seed_lo, r_seed_hi;
    logic [AW-1:0] r_i, n_i, r_idx, n_idx;
    logic [AW-1:0] r_cnt, n_cnt;
    logic r_j, n_j;
    logic r_pair, n_pair;
    logic r_second, n_second;
    logic [1:0] r_cmd, n_cmd;
    logic [63:0] r_limit, n_limit, r_mask, n_mask;
    logic [31:0] r_a, n_a, r_b, n_b;
    logic [63:0] r_lo, n_lo, r_val, n_val;
    logic r_boot, n_boot;

    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wd;
    logic [31:0] mul_x, mul_y, mul_p;
    logic [AW-1:0] nxt, far;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr[$clog2(STATE_WORDS)-1:0]] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr[$clog2(STATE_WORDS)-1:0]];
    end

    assign mul_p = 32'((64'(mul_x) * 64'(mul_y)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_lo <= ResetSeedLo;
            r_seed_hi <= ResetSeedHi;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SEED_LO) r_seed_lo <= i_cfg_data;
            else                           r_seed_hi <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_boot  <= 1'b1;
            r_idx   <= Full;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
            r_idx   <= n_idx;
            if (r_state == ST_OUT && !m_axis_tvalid) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        end
        r_i <= n_i; r_cnt <= n_cnt; r_j <= n_j;
        r_pair <= n_pair; r_second <= n_second; r_cmd <= n_cmd;
        r_limit <= n_limit; r_mask <= n_mask; r_a <= n_a; r_b <= n_b;
        r_lo <= n_lo; r_val <= n_val;
        if (r_state == ST_OUT && !m_axis_tvalid) m_axis_tdata <= r_val;
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_boot;
    assign nxt = (r_i == LastIdx) ? '0 : r_i + 1'b1;
    assign far = (r_i + FarOff >= Full) ? r_i + FarOff - Full : r_i + FarOff;

    always_comb begin
        logic [31:0] y;
        logic [63:0] v;
        n_state = r_state; n_boot = r_boot;
        n_i = r_i; n_idx = r_idx; n_cnt = r_cnt; n_j = r_j; n_pair = r_pair;
        n_second = r_second; n_cmd = r_cmd; n_limit = r_limit; n_mask = r_mask;
        n_a = r_a; n_b = r_b; n_lo = r_lo; n_val = r_val;
        mem_we = 1'b0; mem_addr = r_i; mem_wd = '0;
        mul_x = r_a ^ (r_a >> 30); mul_y = InitMult;
        y = '0; v = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (r_boot) begin
                    n_cmd = CMD_RESEED;
                    n_pair = (r_seed_hi != '0);
                    mem_we = 1'b1; mem_addr = '0;
                    mem_wd = (r_seed_hi != '0) ? PairBase : r_seed_lo;
                    n_i = AW'(1); n_state = ST_S1_RD;
                end else if (s_axis_tvalid) begin
                    n_cmd = s_axis_tdata[1:0];
                    n_limit = s_axis_tdata[65:2];
                    n_mask = fill_mask(s_axis_tdata[65:2]);
                    n_second = 1'b0;
                    unique case (t_cmd'(s_axis_tdata[1:0]))
                        CMD_RESEED: begin
                            n_pair = (r_seed_hi != '0);
                            mem_we = 1'b1; mem_addr = '0;
                            mem_wd = (r_seed_hi != '0) ? PairBase : r_seed_lo;
                            n_i = AW'(1); n_state = ST_S1_RD;
                        end
                        CMD_BOUNDED: begin
                            if (s_axis_tdata[65:2] == '0) begin
                                n_val = '0; n_state = ST_OUT;
                            end else n_state = ST_D_RD;
                        end
                        default: n_state = ST_D_RD;
                    endcase
                end
            end
            ST_S1_RD: begin
                mem_addr = r_i - 1'b1; n_state = ST_S1_MUL;
            end
            ST_S1_MUL: begin
                mul_x = r_rd ^ (r_rd >> 30); mul_y = InitMult;
                mem_we = 1'b1; mem_addr = r_i;
                mem_wd = mul_p + 32'(r_i);
                if (r_i == LastIdx) begin
                    n_idx = Full;
                    if (r_pair) begin
                        n_i = AW'(1); n_j = 1'b0; n_cnt = Full;
                        n_state = ST_P1_RD;
                    end else begin
                        // The seeding after reset returns no transaction.
                        n_val = '0;
                        if (r_boot) begin
                            n_boot = 1'b0; n_state = ST_IDLE;
                        end else n_state = ST_OUT;
                    end
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_S1_RD;
                end
            end
            ST_P1_RD, ST_P2_RD: begin
                mem_addr = r_i - 1'b1;
                n_state = (r_state == ST_P1_RD) ? ST_P1_RD2 : ST_P2_RD2;
            end
            ST_P1_RD2, ST_P2_RD2: begin
                mem_addr = r_i; n_a = r_rd;
                n_state = (r_state == ST_P1_RD2) ? ST_P1_MUL : ST_P2_MUL;
            end
            ST_P1_MUL, ST_P2_MUL: begin
                mul_x = r_a ^ (r_a >> 30);
                mul_y = (r_state == ST_P1_MUL) ? PairMultA : PairMultB;
                n_b = r_rd ^ mul_p;
                n_state = (r_state == ST_P1_MUL) ? ST_P1_WR : ST_P2_WR;
            end
            ST_P1_WR, ST_P2_WR: begin
                mem_we = 1'b1; mem_addr = r_i;
                if (r_state == ST_P1_WR)
                    mem_wd = r_b + (r_j ? r_seed_hi : r_seed_lo) + 32'(r_j);
                else
                    mem_wd = r_b - 32'(r_i);
                n_j = ~r_j;
                n_cnt = r_cnt - 1'b1;
                n_second = (r_state == ST_P2_WR);
                if (r_i == LastIdx) begin
                    n_i = AW'(1); n_state = ST_WRAP_RD;
                end else begin
                    n_i = r_i + 1'b1;
                    if (r_cnt == AW'(1))
                        n_state = (r_state == ST_P1_WR) ? ST_P2_RD : ST_FIN_WR;
                    else
                        n_state = (r_state == ST_P1_WR) ? ST_P1_RD : ST_P2_RD;
                    if (r_cnt == AW'(1) && r_state == ST_P1_WR) n_cnt = LastIdx;
                end
            end
            ST_WRAP_RD: begin
                mem_addr = LastIdx; n_state = ST_WRAP_WR;
            end
            ST_WRAP_WR: begin
                mem_we = 1'b1; mem_addr = '0; mem_wd = r_rd;
                if (r_cnt == '0)
                    n_state = r_second ? ST_FIN_WR : ST_P2_RD;
                else
                    n_state = r_second ? ST_P2_RD : ST_P1_RD;
                if (r_cnt == '0 && !r_second) n_cnt = LastIdx;
            end
            ST_FIN_WR: begin
                mem_we = 1'b1; mem_addr = '0; mem_wd = UpperMask;
                n_idx = Full; n_val = '0;
                if (r_boot) begin
                    n_boot = 1'b0; n_state = ST_IDLE;
                end else n_state = ST_OUT;
            end
            ST_G_RD0: begin
                mem_addr = r_i; n_state = ST_G_RD1;
            end
            ST_G_RD1: begin
                mem_addr = nxt; n_a = r_rd; n_state = ST_G_RD2;
            end
            ST_G_RD2: begin
                mem_addr = far; n_b = r_rd; n_state = ST_G_WR;
            end
            ST_G_WR: begin
                y = (r_a & UpperMask) | (r_b & LowerMask);
                mem_we = 1'b1; mem_addr = r_i;
                mem_wd = r_rd ^ (y >> 1) ^ (y[0] ? MatrixA : 32'd0);
                if (r_i == LastIdx) begin
                    n_idx = '0; n_state = ST_D_RD;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_G_RD0;
                end
            end
            ST_D_RD: begin
                if (r_idx >= Full) begin
                    n_i = '0; n_state = ST_G_RD0;
                end else begin
                    mem_addr = r_idx; n_idx = r_idx + 1'b1; n_state = ST_D_TEMP;
                end
            end
            ST_D_TEMP: begin
                n_a = temper(r_rd); n_state = ST_D_USE;
            end
            ST_D_USE: begin
                unique case (t_cmd'(r_cmd))
                    CMD_DRAW: begin
                        n_val = {32'd0, r_a}; n_state = ST_OUT;
                    end
                    CMD_REAL: begin
                        if (!r_second) begin
                            n_lo = {32'd0, r_a}; n_second = 1'b1; n_state = ST_D_RD;
                        end else begin
                            n_val = ({32'd0, r_lo[31:0] >> 5} << 26) | 64'(r_a >> 6);
                            n_state = ST_OUT;
                        end
                    end
                    default: begin
                        if (r_limit[63:32] == '0) begin
                            v = {32'd0, r_a} & r_mask;
                            if (v > r_limit) n_state = ST_D_RD;
                            else begin n_val = v; n_state = ST_OUT; end
                        end else if (!r_second) begin
                            n_lo = {32'd0, r_a}; n_second = 1'b1; n_state = ST_D_RD;
                        end else begin
                            v = {r_a, r_lo[31:0]} & r_mask;
                            n_second = 1'b0;
                            if (v > r_limit) n_state = ST_D_RD;
                            else begin n_val = v; n_state = ST_OUT; end
                        end
                    end
                endcase
            end
            ST_OUT: begin
                if (!m_axis_tvalid) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE)) else $error("ready while busy");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= Full) else $error("draw index out of range");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("result not presented");
`endif
endmodule
`default_nettype wire
